>>> rtl/assert_macros.svh
// Assertion macros shared by the hash core modules.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check: whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle check: whenever ante holds, cons must hold in the cycle after.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/md5ch_pkg.sv
// Package for the chained MD5 hash core: item codes, queue types and round tables.
// Depends on nothing; used by every module of the core.
`default_nettype none
package md5ch_pkg;

    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } item_t;

    // Handshake between the front queue and the engine.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

    function automatic logic [31:0] round_k(input logic [5:0] rnd);
        logic [31:0] k;
        unique case (rnd)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
        logic [4:0] s;
        unique case ({rnd[5:4], rnd[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // Message word index; the round group offset drops out modulo 16.
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] j;
        logic [3:0] g;
        j = rnd[3:0];
        unique case (rnd[5:4])
            2'd0: g = j;
            2'd1: g = 4'((j << 2) + j + 4'd1);
            2'd2: g = 4'((j << 1) + j + 4'd5);
            2'd3: g = 4'((j << 3) - j);
            default: g = j;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (grp)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (d & b) | (~d & c);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

>>> rtl/md5ch_front.sv
// Front end of the hash core: accepts input words, drops unused codes, queues the rest.
// Depends on md5ch_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module md5ch_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire md5ch_pkg::item_t   s_item,
    output md5ch_pkg::queue_out_t   q_out,
    input  wire logic               q_pop
);

    md5ch_pkg::item_t queue_mem [md5ch_pkg::QUEUE_DEPTH];
    logic [md5ch_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [md5ch_pkg::QUEUE_AW:0]   fill_reg, fill_next;
    logic accept, push, pop;

    assign s_tready = (fill_reg != (md5ch_pkg::QUEUE_AW+1)'(md5ch_pkg::QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;
    // Opcode 3 means nothing: it is taken and discarded here.
    assign push     = accept && (s_item.opcode == md5ch_pkg::OP_RESET ||
                                 s_item.opcode == md5ch_pkg::OP_DATA ||
                                 s_item.opcode == md5ch_pkg::OP_END);
    assign pop      = q_pop && q_out.valid;

    assign q_out.valid = (fill_reg != '0);
    assign q_out.item  = queue_mem[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= s_item;
        end
    end

    `ASSERT_IMPLY(a_fill_bound, 1'b1, fill_reg <= (md5ch_pkg::QUEUE_AW+1)'(md5ch_pkg::QUEUE_DEPTH), "queue overfilled")
    `ASSERT_NEXT(a_pop_moves_ptr, pop && !push, fill_reg == $past(fill_reg) - 1'b1, "pop lost")

endmodule
`default_nettype wire

>>> rtl/md5ch_engine.sv
// Back end of the hash core: block buffer, padding, 64-round compression, digest register.
// Depends on md5ch_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module md5ch_engine (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire md5ch_pkg::queue_out_t q_in,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [127:0]               m_tdata
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_ADD   = 5'b00100,
        ST_PAD2  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] chain_reg [4];
    logic [31:0] blk_reg [16];
    logic [31:0] count_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  rnd_reg;
    logic        last_reg, second_reg;
    logic        out_valid_reg;
    logic [127:0] out_data_reg;

    logic [5:0]  pos;
    logic [31:0] sum, rot_in;
    logic [63:0] rot_wide;
    logic [31:0] len_bits;
    logic        take;

    assign pos      = count_reg[5:0];
    assign len_bits = {count_reg[28:0], 3'b000};
    assign take     = (state_reg == ST_IDLE) && q_in.valid;
    assign q_pop    = take;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // One MD5 step per cycle.
    assign rot_in   = a_reg + md5ch_pkg::round_f(rnd_reg[5:4], b_reg, c_reg, d_reg)
                    + md5ch_pkg::round_k(rnd_reg) + blk_reg[md5ch_pkg::msg_index(rnd_reg)];
    assign rot_wide = {rot_in, rot_in} << md5ch_pkg::rot_amt(rnd_reg);
    assign sum      = b_reg + rot_wide[63:32];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take && ((q_in.item.opcode == md5ch_pkg::OP_DATA && pos == 6'd63) ||
                             q_in.item.opcode == md5ch_pkg::OP_END)) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (rnd_reg == 6'd63) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (second_reg) begin
                    state_next = ST_PAD2;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_PAD2: state_next = ST_ROUND;
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chain_reg[0]  <= md5ch_pkg::IV_A;
            chain_reg[1]  <= md5ch_pkg::IV_B;
            chain_reg[2]  <= md5ch_pkg::IV_C;
            chain_reg[3]  <= md5ch_pkg::IV_D;
            count_reg     <= '0;
            rnd_reg       <= '0;
            last_reg      <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // A new digest may replace the one taken at this same edge.
            if (state_reg == ST_EMIT && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        if (q_in.item.opcode == md5ch_pkg::OP_RESET) begin
                            chain_reg[0] <= md5ch_pkg::IV_A;
                            chain_reg[1] <= md5ch_pkg::IV_B;
                            chain_reg[2] <= md5ch_pkg::IV_C;
                            chain_reg[3] <= md5ch_pkg::IV_D;
                            count_reg    <= '0;
                        end else if (q_in.item.opcode == md5ch_pkg::OP_DATA) begin
                            count_reg <= count_reg + 32'd1;
                            last_reg  <= 1'b0;
                        end else begin
                            last_reg   <= 1'b1;
                            second_reg <= (pos >= 6'd56);
                        end
                    end
                end
                ST_ROUND: rnd_reg <= rnd_reg + 6'd1;
                ST_ADD: begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                end
                ST_PAD2: second_reg <= 1'b0;
                ST_EMIT: begin
                    if (!out_valid_reg || m_tready) begin
                        count_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working variables load from the chain at each block start.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ROUND) begin
            a_reg <= d_reg;
            b_reg <= sum;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end else begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        if (state_reg == ST_EMIT && (!out_valid_reg || m_tready)) begin
            out_data_reg <= {chain_reg[3], chain_reg[2], chain_reg[1], chain_reg[0]};
        end
    end

    // Block buffer: byte writes for data, padding from the end byte on, full rewrite in ST_PAD2.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            if (take && q_in.item.opcode == md5ch_pkg::OP_DATA && pos[5:2] == 4'(i)) begin
                blk_reg[i][pos[1:0]*8 +: 8] <= q_in.item.data_byte;
            end else if (take && q_in.item.opcode == md5ch_pkg::OP_END) begin
                if (pos < 6'd56 && i == 14) begin
                    blk_reg[i] <= len_bits;
                end else if (pos < 6'd56 && i == 15) begin
                    blk_reg[i] <= '0;
                end else if (pos[5:2] == 4'(i)) begin
                    for (int k = 0; k < 4; k++) begin
                        if (pos[1:0] == 2'(k)) begin
                            blk_reg[i][k*8 +: 8] <= md5ch_pkg::PAD_MARK;
                        end else if (pos[1:0] < 2'(k)) begin
                            blk_reg[i][k*8 +: 8] <= 8'h00;
                        end
                    end
                end else if (pos[5:2] < 4'(i)) begin
                    blk_reg[i] <= '0;
                end
            end else if (state_reg == ST_PAD2) begin
                blk_reg[i] <= (i == 14) ? len_bits : 32'h0;
            end
        end
    end

    `ASSERT_IMPLY(a_add_after_last_round, state_reg == ST_ADD, rnd_reg == 6'd0, "round count off")
    `ASSERT_NEXT(a_emit_sets_valid, state_reg == ST_EMIT && (!out_valid_reg || m_tready), out_valid_reg && count_reg == 32'd0, "digest not presented")

endmodule
`default_nettype wire

>>> rtl/md5_chained_message_hash_core.sv
// Top level of the chained MD5 hash core: input queue front end and compression engine.
// Depends on md5ch_pkg, md5ch_front and md5ch_engine.
`default_nettype none
// Chained MD5 hash core. Each input word carries an opcode and a byte: opcode 0
// restores the chaining words to the MD5 initial values and drops any partial
// message, opcode 1 appends one message byte, opcode 2 ends the message, and
// opcode 3 is ignored. Ending a message pads it (0x80, zeros, 32-bit bit length),
// compresses the last one or two blocks and presents the four chaining words as
// one output word; the next message chains on from them. A data byte is stored in
// the block buffer; the 64th byte of a block also starts the compression: 64
// rounds, one per cycle on a single round unit, then the final add. An end word
// compresses the padded block, or two when the padding spills into a second block,
// then loads the digest register. The engine takes no new word before it is done. A
// four-word input queue takes words until full while the engine compresses, and
// the digest register holds its result while the engine goes on with later words.
module md5_chained_message_hash_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // [1:0] opcode, [9:2] data_byte, [15:10] zero
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata    // [31:0] digest_a, [63:32] digest_b,
                                         // [95:64] digest_c, [127:96] digest_d
);

    md5ch_pkg::item_t      s_item;
    md5ch_pkg::queue_out_t q_out;
    logic                  q_pop;

    assign s_item.opcode    = s_tdata[1:0];
    assign s_item.data_byte = s_tdata[9:2];

    md5ch_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .q_out    (q_out),
        .q_pop    (q_pop)
    );

    md5ch_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_in     (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

>>> tb/md5_chained_message_hash_core_tb.sv
// Testbench for the chained MD5 hash core: directed table, padding edges, random messages.
// Depends on md5ch_pkg and md5_chained_message_hash_core; holds its own digest predictor.
`timescale 1ns / 100ps
`default_nettype none
module md5_chained_message_hash_core_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]   opcode;
        logic [7:0]   data_byte;
        logic         has_digest;
        logic [127:0] digest;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;

    logic [127:0] digest_queue[$];
    logic [31:0]  chain[4];
    logic [31:0]  block[16];
    logic [31:0]  byte_count;
    int           fail_count = 0;
    bit           idle_off = 1'b0;

    // Digests of the empty message and of "a" (one byte 0x61), little-endian words.
    localparam logic [127:0] EMPTY_DIGEST = {32'h7e42f8ec, 32'h980980e9, 32'h04b2008f,
                                             32'hd98c1dd4};
    localparam logic [127:0] A_DIGEST     = {32'h61267769, 32'he299c331, 32'ha8b6f1c0,
                                             32'hb975c10c};

    md5_chained_message_hash_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    // One MD5 compression of the current block onto the chaining words.
    task automatic compress_md5();
        logic [31:0] a, b, c, d, f, t, sum;
        int g, s;
        int sh[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        logic [31:0] kt[64] = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
            32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
            32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
            32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
            32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
            32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
            32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
            32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
            32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
            32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                f = (b & c) | (~b & d); g = i;
            end else if (i < 32) begin
                f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
            end else if (i < 48) begin
                f = b ^ c ^ d; g = (3 * i + 5) % 16;
            end else begin
                f = c ^ (b | ~d); g = (7 * i) % 16;
            end
            s = sh[(i / 16) * 4 + i % 4];
            sum = a + f + kt[i] + block[g];
            t = d; d = c; c = b;
            b = b + ((sum << s) | (sum >> (32 - s)));
            a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endtask

    task automatic place_byte(input int pos, input logic [7:0] value);
        block[pos / 4][(pos % 4) * 8 +: 8] = value;
    endtask

    function automatic void restore_iv();
        chain[0] = md5ch_pkg::IV_A; chain[1] = md5ch_pkg::IV_B;
        chain[2] = md5ch_pkg::IV_C; chain[3] = md5ch_pkg::IV_D;
    endfunction

    // Advance the predicted state by one accepted word; sets emits when a digest is due.
    task automatic predict_word(input logic [1:0] op, input logic [7:0] value,
                                output bit emits, output logic [127:0] digest);
        int pos;
        pos = byte_count % 64;
        emits = 1'b0;
        digest = '0;
        case (op)
            md5ch_pkg::OP_RESET: begin
                restore_iv();
                byte_count = 0;
            end
            md5ch_pkg::OP_DATA: begin
                place_byte(pos, value);
                byte_count++;
                if (pos == 63) compress_md5();
            end
            md5ch_pkg::OP_END: begin
                place_byte(pos, md5ch_pkg::PAD_MARK);
                for (int p = pos + 1; p < 64; p++) place_byte(p, 8'h00);
                // Long padding: the length no longer fits, so a second block follows.
                if (pos >= 56) begin
                    compress_md5();
                    foreach (block[i]) block[i] = '0;
                end
                block[14] = byte_count << 3;
                block[15] = '0;
                compress_md5();
                byte_count = 0;
                emits = 1'b1;
                digest = {chain[3], chain[2], chain[1], chain[0]};
            end
            default: ;
        endcase
    endtask

    // Drive one word; the predictor runs when the handshake completes.
    task automatic send_word(input logic [1:0] op, input logic [7:0] value,
                             input bit has_typed, input logic [127:0] typed);
        bit emits;
        bit ready_now;
        logic [127:0] digest;
        if (!idle_off && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, value, op};
        // Ready only moves at rising edges, so its value ahead of the edge decides.
        forever begin
            ready_now = s_tready;
            @(posedge aclk);
            if (ready_now) break;
            @(negedge aclk);
        end
        predict_word(op, value, emits, digest);
        if (emits) begin
            if (has_typed && typed !== digest) begin
                $display("%0t: digest expected %h, predictor gives %h", $time, typed, digest);
                fail_count++;
            end
            digest_queue.push_back(digest);
        end
        @(negedge aclk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send_word(md5ch_pkg::OP_DATA, 8'($urandom), 1'b0, '0);
        send_word(md5ch_pkg::OP_END, 8'($urandom), 1'b0, '0);
    endtask

    // Result side: random stalls, compare against the oldest expected digest.
    initial begin
        @(posedge aresetn);
        forever begin
            bit           seen_valid;
            logic [127:0] seen_data;
            @(negedge aclk);
            if (!idle_off && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            m_tready <= 1'b1;
            // The outputs are registers, so they hold their value up to the edge.
            seen_valid = m_tvalid;
            seen_data = m_tdata;
            @(posedge aclk);
            if (seen_valid) begin
                if (digest_queue.size() == 0) begin
                    $display("%0t: unexpected digest, expected none, actual %h",
                             $time, seen_data);
                    fail_count++;
                end else begin
                    logic [127:0] want;
                    want = digest_queue.pop_front();
                    for (int w = 0; w < 4; w++)
                        if (seen_data[w*32 +: 32] !== want[w*32 +: 32]) begin
                            $display("%0t: digest word %0d expected %h, actual %h",
                                     $time, w, want[w*32 +: 32], seen_data[w*32 +: 32]);
                            fail_count++;
                        end
                end
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        int sent;
        int waited;
        restore_iv();
        foreach (block[i]) block[i] = '0;
        byte_count = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table: unused opcode and empty message right after reset, one byte "a",
        // then byte extremes, back-to-back ends on the chained state and a reset mid-message.
        rows.push_back('{OP_UNUSED, 8'hff, 1'b0, '0});
        rows.push_back('{md5ch_pkg::OP_END, 8'h00, 1'b1, EMPTY_DIGEST});
        rows.push_back('{md5ch_pkg::OP_RESET, 8'hff, 1'b0, '0});
        rows.push_back('{md5ch_pkg::OP_DATA, 8'h61, 1'b0, '0});
        rows.push_back('{md5ch_pkg::OP_END, 8'hff, 1'b1, A_DIGEST});
        rows.push_back('{md5ch_pkg::OP_DATA, 8'h00, 1'b0, '0});
        rows.push_back('{md5ch_pkg::OP_DATA, 8'hff, 1'b0, '0});
        rows.push_back('{md5ch_pkg::OP_DATA, 8'haa, 1'b0, '0});
        rows.push_back('{md5ch_pkg::OP_DATA, 8'h55, 1'b0, '0});
        rows.push_back('{OP_UNUSED, 8'h00, 1'b0, '0});
        rows.push_back('{md5ch_pkg::OP_END, 8'h00, 1'b0, '0});
        rows.push_back('{md5ch_pkg::OP_END, 8'h00, 1'b0, '0});
        rows.push_back('{md5ch_pkg::OP_DATA, 8'h12, 1'b0, '0});
        rows.push_back('{md5ch_pkg::OP_RESET, 8'h00, 1'b0, '0});
        rows.push_back('{md5ch_pkg::OP_END, 8'h00, 1'b1, EMPTY_DIGEST});
        foreach (rows[i]) send_word(rows[i].opcode, rows[i].data_byte,
                                    rows[i].has_digest, rows[i].digest);
        // Padding boundaries: 55, 56, 63, 64 and 119 byte messages.
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
        send_message(119);

        // Random messages, mostly short, with resets and unused words mixed in.
        sent = 0;
        while (sent < 1650) begin
            int len;
            len = -1;
            if (sent > 1400) idle_off = 1'b1;
            case ($urandom_range(0, 9))
                0: begin
                    send_word(md5ch_pkg::OP_RESET, 8'($urandom), 1'b0, '0);
                    sent++;
                end
                1: begin
                    send_word(OP_UNUSED, 8'($urandom), 1'b0, '0);
                    sent++;
                end
                2: len = $urandom_range(50, 130);
                default: len = $urandom_range(0, 20);
            endcase
            if (len >= 0) begin
                send_message(len);
                sent += len + 1;
            end
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (digest_queue.size() != 0 && waited < 200000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (300) @(negedge aclk);
        if (fail_count == 0 && digest_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
